// ===== rtl/core/amrt_pkg.sv =====
// ----------------------------------------------------------------------------
// amrt_pkg: shared types and constants for the approximate-match row unit
// Holds the beat formats of the item, command and result channels, the
// configuration register indexes and the cell arithmetic helpers.
// ----------------------------------------------------------------------------
package amrt_pkg;

  localparam int CELL_W      = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int POS_W       = 10;
  localparam int SYM_W       = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;

  localparam logic [CFG_DATA_W-1:0] TEXT_LENGTH_RESET = 11'd1;
  localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET   = 11'd1;

  typedef enum logic [0:0] {
    OP_TEXT = 1'b0,
    OP_ROW  = 1'b1
  } op_t;

  typedef struct packed {
    logic             action;
    logic [POS_W-1:0] text_position;
    logic [SYM_W-1:0] symbol;
    logic             start_req;
    logic             last;
  } item_t;

  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] text_position;
    logic [SYM_W-1:0] symbol;
    logic             start_req;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] row_number;
    logic              row_passes;
    logic [CELL_W-1:0] first_passing_row;
    logic              final_res;
  } result_t;

  // Values above the cell range behave like the saturated cell value.
  function automatic logic [CELL_W-1:0] cell_clamp(input logic [31:0] v);
    return (v > 32'(CELL_MAX)) ? CELL_MAX : v[CELL_W-1:0];
  endfunction

endpackage

// ===== rtl/core/amrt_front.sv =====
// ----------------------------------------------------------------------------
// amrt_front: item intake and command queue
// Accepts input beats, turns them into text-write or row commands, drops
// text writes outside the store and queues the rest for the row engine.
// ----------------------------------------------------------------------------
module amrt_front #(
  parameter int MAX_TEXT    = 1024,
  parameter int SYMBOL_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  amrt_pkg::item_t item,
  input  logic           item_valid,
  output logic           item_ready,
  output amrt_pkg::cmd_t cmd,
  output logic           cmd_valid,
  input  logic           cmd_ready
);

  localparam int QAW = $clog2(amrt_pkg::QUEUE_DEPTH);
  localparam int QCW = QAW + 1;

  amrt_pkg::cmd_t queue [amrt_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  amrt_pkg::cmd_t cmd_in;
  logic           keep;
  logic           push;
  logic           pop;

  always_comb begin
    cmd_in.op            = item.action ? amrt_pkg::OP_ROW : amrt_pkg::OP_TEXT;
    cmd_in.text_position = item.text_position;
    cmd_in.symbol        = item.symbol & amrt_pkg::SYM_W'((1 << SYMBOL_BITS) - 1);
    cmd_in.start_req     = item.action & item.start_req;
    cmd_in.last          = item.last;
  end

  assign keep       = item.action || (32'(item.text_position) < MAX_TEXT);
  assign item_ready = (count != QCW'(amrt_pkg::QUEUE_DEPTH));
  assign cmd_valid  = (count != '0);
  assign cmd        = queue[rd_ptr];
  assign push       = item_valid && item_ready && keep;
  assign pop        = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10: count <= count + QCW'(1);
        2'b01: count <= count - QCW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/amrt_engine.sv =====
// ----------------------------------------------------------------------------
// amrt_engine: row engine
// Executes queued commands: stores text symbols and builds one edit-distance
// row per pattern symbol, one column per cycle through the row memory, then
// loads the row result into the output register.
// ----------------------------------------------------------------------------
module amrt_engine #(
  parameter int MAX_TEXT    = 1024,
  parameter int MAX_PATTERN = 1024,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  amrt_pkg::cmd_t                      cmd,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  logic [amrt_pkg::CFG_DATA_W-1:0]     text_length,
  input  logic [amrt_pkg::CFG_DATA_W-1:0]     threshold,
  output amrt_pkg::result_t                   result,
  output logic                                res_valid,
  input  logic                                res_ready
);

  localparam int AW = $clog2(MAX_TEXT);
  localparam int NW = AW + 1;
  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int CL = amrt_pkg::CELL_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  logic [SYMBOL_BITS-1:0] text_mem [MAX_TEXT];
  logic [CL-1:0]          row_mem  [MAX_TEXT];

  logic [SYMBOL_BITS-1:0] sym;
  logic                   last_flag;
  logic [NW-1:0]          row_len;
  logic [NW-1:0]          col;
  logic [NW-1:0]          fill;
  logic [CW-1:0]          counter;
  logic [CW-1:0]          found;
  logic [CL-1:0]          left;
  logic [CL-1:0]          diag;
  logic                   pass;
  logic [SYMBOL_BITS-1:0] text_rd;
  logic [CL-1:0]          row_rd;

  logic          pop;
  logic          text_we;
  logic          row_we;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] cnt_base;
  logic [CW-1:0] cnt_new;
  logic [NW-1:0] n_clamp;
  logic [CL-1:0] up;
  logic [CL:0]   sum_up;
  logic [CL:0]   sum_left;
  logic [CL:0]   sum_diag;
  logic [CL:0]   min_a;
  logic [CL:0]   min_b;
  logic [CL-1:0] cell_val;
  logic          last_col;
  logic          out_free;
  logic [CW-1:0] found_next;

  assign cmd_ready = (state == ST_IDLE);
  assign pop       = cmd_valid && cmd_ready;
  assign text_we   = pop && (cmd.op == amrt_pkg::OP_TEXT);
  assign row_we    = (state == ST_RUN);
  assign rd_addr   = (state == ST_RUN) ? AW'(col + NW'(1)) : '0;

  assign cnt_base = cmd.start_req ? '0 : counter;
  assign cnt_new  = (32'(cnt_base) < MAX_PATTERN) ? cnt_base + CW'(1) : cnt_base;
  assign n_clamp  = (32'(text_length) > MAX_TEXT) ? NW'(MAX_TEXT) : NW'(text_length);

  assign up       = (col < fill) ? row_rd : '0;
  assign sum_up   = {1'b0, up} + (CL+1)'(1);
  assign sum_left = {1'b0, left} + (CL+1)'(1);
  assign sum_diag = {1'b0, diag} + (CL+1)'(text_rd != sym);
  assign min_a    = (sum_up < sum_left) ? sum_up : sum_left;
  assign min_b    = (min_a < sum_diag) ? min_a : sum_diag;
  assign cell_val = min_b[CL] ? amrt_pkg::CELL_MAX : min_b[CL-1:0];

  assign last_col   = (NW'(col + NW'(1)) == row_len);
  assign out_free   = !res_valid || res_ready;
  assign found_next = (pass && (found == '0)) ? counter : found;

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[AW'(cmd.text_position)] <= cmd.symbol[SYMBOL_BITS-1:0];
    end
    text_rd <= text_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[col[AW-1:0]] <= cell_val;
    end
    row_rd <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      counter   <= '0;
      found     <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      if ((state == ST_DONE) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop && (cmd.op == amrt_pkg::OP_ROW)) begin
            sym       <= cmd.symbol[SYMBOL_BITS-1:0];
            last_flag <= cmd.last;
            if (cmd.start_req) begin
              found <= '0;
              fill  <= '0;
            end
            counter <= cnt_new;
            diag    <= amrt_pkg::cell_clamp(32'(cnt_base));
            left    <= amrt_pkg::cell_clamp(32'(cnt_new));
            pass    <= 1'b1;
            col     <= '0;
            row_len <= n_clamp;
            state   <= (n_clamp == '0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          diag <= up;
          left <= cell_val;
          pass <= pass && (cell_val >= threshold);
          col  <= col + NW'(1);
          if (last_col) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result.row_number        <= CL'(counter);
            result.row_passes        <= pass;
            result.first_passing_row <= CL'(found_next);
            result.final_res         <= last_flag;
            found                    <= found_next;
            if (row_len > fill) begin
              fill <= row_len;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/approx_match_row_threshold_unit.sv =====
// ----------------------------------------------------------------------------
// approx_match_row_threshold_unit: approximate-match row threshold unit
// Holds a text and builds one approximate-match edit-distance row per pattern
// symbol, reporting whether every text cell reaches the threshold.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals                            Beat
// item     in         item_valid, item_ready, item       text write or pattern
// result   out        res_valid, res_ready, result       one per pattern symbol
// cfg      in         cfg_valid, cfg_ready, cfg_index,   register write
//                     cfg_data
//
// A pattern symbol sweeps the row memory one column per cycle over
// text_length columns, with text_length clamped to MAX_TEXT.
// A four-entry command queue lets the intake keep taking beats while a row is
// built, and the output register lets the next row start while a result waits.
// Reset is synchronous and leaves the row store reading as zeros without a
// clearing pass; configuration writes are always taken.
// ----------------------------------------------------------------------------
module approx_match_row_threshold_unit #(
  parameter int MAX_TEXT    = 1024,
  parameter int MAX_PATTERN = 1024,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  amrt_pkg::item_t                  item,
  input  logic                             item_valid,
  output logic                             item_ready,
  output amrt_pkg::result_t                result,
  output logic                             res_valid,
  input  logic                             res_ready,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [amrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [amrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  amrt_pkg::cmd_t                   cmd;
  logic                             cmd_valid;
  logic                             cmd_ready;
  logic [amrt_pkg::CFG_DATA_W-1:0]  text_length;
  logic [amrt_pkg::CFG_DATA_W-1:0]  threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= amrt_pkg::TEXT_LENGTH_RESET;
      threshold   <= amrt_pkg::THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        amrt_pkg::REG_TEXT_LENGTH: text_length <= cfg_data;
        amrt_pkg::REG_THRESHOLD:   threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  amrt_front #(
    .MAX_TEXT    (MAX_TEXT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready)
  );

  amrt_engine #(
    .MAX_TEXT    (MAX_TEXT),
    .MAX_PATTERN (MAX_PATTERN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .text_length (text_length),
    .threshold   (threshold),
    .result      (result),
    .res_valid   (res_valid),
    .res_ready   (res_ready)
  );

endmodule

// ===== rtl/core/amrt_checker.sv =====
// ----------------------------------------------------------------------------
// amrt_checker: port-level checks for the approximate-match row unit
// Watches the result channel of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module amrt_checker #(
  parameter int MAX_PATTERN = 1024
) (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input amrt_pkg::result_t result
);

  localparam bit NO_WRAP = (MAX_PATTERN < 2048);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(result))
    else $error("A stalled result beat changed or was dropped.");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("A result beat is valid right after reset.");

  a_row_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && NO_WRAP |-> result.row_number != '0)
    else $error("A result beat reports row zero.");

  a_pass_recorded: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.row_passes && NO_WRAP |-> result.first_passing_row != '0)
    else $error("A passing row left the first passing row empty.");

endmodule

bind approx_match_row_threshold_unit amrt_checker #(
  .MAX_PATTERN (MAX_PATTERN)
) u_amrt_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .result    (result)
);

// ===== test/approx_match_row_threshold_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// approx_match_row_threshold_unit_test: self-checking bench for the row unit
// Loads text symbols and feeds pattern symbols through the item channel while
// a local edit-distance row predictor tracks the text, the row store, the row
// counter and the first passing row. Every result beat is compared field by
// field against the oldest predicted row. Directed beats cover the field
// extremes, a zero text length and start flags on text writes; random
// suffixes then run under several idle mixes.
// ----------------------------------------------------------------------------
module approx_match_row_threshold_unit_test;

  localparam int MAX_TEXT    = 1024;
  localparam int MAX_PATTERN = 1024;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASE_ITEMS = 140;

  logic clk;
  logic rst = 1'b1;

  amrt_pkg::item_t                 item = '0;
  logic                            item_valid = 1'b0;
  logic                            item_ready;
  amrt_pkg::result_t               result;
  logic                            res_valid;
  logic                            res_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [amrt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [amrt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  approx_match_row_threshold_unit dut (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .result     (result),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor state.
  logic [amrt_pkg::SYM_W-1:0]      text_copy [MAX_TEXT];
  logic [amrt_pkg::CELL_W-1:0]     row_copy [MAX_TEXT];
  int unsigned                     rows_built = 0;
  int unsigned                     first_pass_row = 0;
  logic [amrt_pkg::CFG_DATA_W-1:0] len_cfg = amrt_pkg::TEXT_LENGTH_RESET;
  logic [amrt_pkg::CFG_DATA_W-1:0] thr_cfg = amrt_pkg::THRESHOLD_RESET;

  amrt_pkg::item_t   item_backlog [$];
  amrt_pkg::result_t predicted_rows [$];
  amrt_pkg::result_t want_row;
  amrt_pkg::result_t oldest_row;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned phase_items = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned text_sent = 0;
  int unsigned rows_sent = 0;
  int unsigned rows_passed = 0;
  int unsigned peak_row = 0;
  int unsigned settings_used = 0;
  logic [amrt_pkg::SYM_W-1:0] alpha_base = '0;

  initial begin
    for (int l = 0; l < MAX_TEXT; l++) begin
      text_copy[l] = '0;
      row_copy[l] = '0;
    end
  end

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Builds the next edit-distance row and returns the result it reports.
  function automatic amrt_pkg::result_t next_row_summary(amrt_pkg::item_t beat);
    int unsigned n;
    int unsigned diag;
    int unsigned left;
    int unsigned up;
    int unsigned v;
    bit pass;
    amrt_pkg::result_t r;
    if (beat.start_req) begin
      for (int l = 0; l < MAX_TEXT; l++) row_copy[l] = '0;
      rows_built = 0;
      first_pass_row = 0;
    end
    n = (len_cfg > MAX_TEXT) ? MAX_TEXT : len_cfg;
    diag = rows_built;
    if (rows_built < MAX_PATTERN) rows_built++;
    left = rows_built;
    pass = 1'b1;
    for (int l = 0; l < n; l++) begin
      up = row_copy[l];
      v = diag + ((text_copy[l] == beat.symbol) ? 0 : 1);
      if (up + 1 < v) v = up + 1;
      if (left + 1 < v) v = left + 1;
      if (v > amrt_pkg::CELL_MAX) v = amrt_pkg::CELL_MAX;
      diag = up;
      row_copy[l] = v[amrt_pkg::CELL_W-1:0];
      left = v;
      if (v < thr_cfg) pass = 1'b0;
    end
    if (pass && first_pass_row == 0) first_pass_row = rows_built;
    r.row_number = rows_built[amrt_pkg::CELL_W-1:0];
    r.row_passes = pass;
    r.first_passing_row = first_pass_row[amrt_pkg::CELL_W-1:0];
    r.final_res = beat.last;
    return r;
  endfunction

  // Sender: one beat at a time from the backlog, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        if (item.action == amrt_pkg::OP_ROW) begin
          want_row = next_row_summary(item);
          predicted_rows.push_back(want_row);
          rows_sent++;
          if (want_row.row_passes) rows_passed++;
          if (want_row.row_number > peak_row) peak_row = want_row.row_number;
        end else begin
          text_copy[item.text_position] = item.symbol;
          text_sent++;
        end
        items_taken++;
      end
      if (!item_valid || item_ready) begin
        if (item_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          item <= item_backlog.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    errors++;
  endtask

  // Checker: each result beat against the oldest predicted row.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (predicted_rows.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual row %0d", $time,
                 result.row_number);
        errors++;
      end else begin
        oldest_row = predicted_rows.pop_front();
        if (result.row_number !== oldest_row.row_number)
          report_mismatch("row_number", oldest_row.row_number, result.row_number);
        if (result.row_passes !== oldest_row.row_passes)
          report_mismatch("row_passes", oldest_row.row_passes, result.row_passes);
        if (result.first_passing_row !== oldest_row.first_passing_row)
          report_mismatch("first_passing_row", oldest_row.first_passing_row,
                          result.first_passing_row);
        if (result.final_res !== oldest_row.final_res)
          report_mismatch("final_res", oldest_row.final_res, result.final_res);
      end
    end
  end

  task automatic write_reg(logic [amrt_pkg::CFG_IDX_W-1:0] idx,
                           logic [amrt_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      amrt_pkg::REG_TEXT_LENGTH: len_cfg = value;
      amrt_pkg::REG_THRESHOLD: thr_cfg = value;
      default: ;
    endcase
  endtask

  task automatic set_lengths(int unsigned len, int unsigned thr);
    write_reg(amrt_pkg::REG_TEXT_LENGTH, len[amrt_pkg::CFG_DATA_W-1:0]);
    write_reg(amrt_pkg::REG_THRESHOLD, thr[amrt_pkg::CFG_DATA_W-1:0]);
    settings_used++;
  endtask

  task automatic queue_text(int unsigned pos, int unsigned sym, bit start, bit fin);
    amrt_pkg::item_t b;
    b.action = amrt_pkg::OP_TEXT;
    b.text_position = pos[amrt_pkg::POS_W-1:0];
    b.symbol = sym[amrt_pkg::SYM_W-1:0];
    b.start_req = start;
    b.last = fin;
    item_backlog.push_back(b);
    items_queued++;
    phase_items++;
  endtask

  task automatic queue_row(int unsigned sym, bit start, bit fin);
    amrt_pkg::item_t b;
    b.action = amrt_pkg::OP_ROW;
    b.text_position = $urandom_range(0, MAX_TEXT - 1);
    b.symbol = sym[amrt_pkg::SYM_W-1:0];
    b.start_req = start;
    b.last = fin;
    item_backlog.push_back(b);
    items_queued++;
    phase_items++;
  endtask

  // Waits until every beat is taken and every row has come back.
  task automatic drain();
    while (items_taken != items_queued || predicted_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    phase_items = 0;
  endtask

  function automatic int unsigned pick_symbol();
    if ($urandom_range(0, 9) < 8) return alpha_base + $urandom_range(0, 3);
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int unsigned len;
    int unsigned thr;
    int unsigned k;
    int unsigned r;
    int unsigned gaps [4];
    int unsigned stalls [4];
    gaps = '{0, 82, 0, 36};
    stalls = '{0, 0, 82, 36};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, start and last on text writes, suffix ends.
    set_lengths(4, 1);
    queue_text(0, 8'h00, 1'b0, 1'b0);
    queue_text(1, 8'hFF, 1'b0, 1'b0);
    queue_text(2, 8'hA5, 1'b0, 1'b0);
    queue_text(3, 8'h5A, 1'b1, 1'b1);
    queue_text(MAX_TEXT - 1, 8'hFF, 1'b1, 1'b0);
    queue_text(MAX_TEXT / 2, 8'h01, 1'b0, 1'b1);
    queue_row(8'h00, 1'b1, 1'b0);
    queue_row(8'hFF, 1'b0, 1'b0);
    queue_row(8'h33, 1'b0, 1'b0);
    queue_row(8'hA5, 1'b0, 1'b1);
    queue_row(8'h5A, 1'b0, 1'b0);
    queue_row(8'h33, 1'b1, 1'b1);
    queue_row(8'h00, 1'b0, 1'b0);
    drain();

    // A text length of zero leaves no cells, so every row passes.
    set_lengths(0, amrt_pkg::CELL_MAX);
    queue_row(8'h7E, 1'b1, 1'b0);
    queue_row(8'h81, 1'b0, 1'b1);
    drain();

    // Random suffixes with interleaved text updates and noise beats.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      r = $urandom_range(0, 9);
      len = (r == 0) ? $urandom_range(33, 64) : (r < 3) ? $urandom_range(13, 32)
                                                        : $urandom_range(1, 12);
      thr = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
      set_lengths(len, thr);
      alpha_base = $urandom_range(0, 252);
      for (int p = 0; p < len; p++) queue_text(p, pick_symbol(), 1'b0, 1'b0);
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 75) begin
          k = $urandom_range(1, 12);
          for (int j = 0; j < k; j++) begin
            if ($urandom_range(0, 9) == 0)
              queue_text($urandom_range(0, len - 1), pick_symbol(), 1'b0, 1'b0);
            queue_row(pick_symbol(), j == 0, j == k - 1);
          end
        end else if (r < 87) begin
          queue_text($urandom_range(0, MAX_TEXT - 1), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        end else begin
          queue_row(pick_symbol(), $urandom_range(0, 1), $urandom_range(0, 1));
        end
      end
      drain();
    end

    if (predicted_rows.size() != 0) begin
      $display("%0t: %0d predicted rows never came back", $time, predicted_rows.size());
      errors++;
    end
    $display("Covered %0d text writes and %0d pattern rows over %0d register settings.",
             text_sent, rows_sent, settings_used);
    $display("%0d rows passed their threshold; the row counter reached %0d.",
             rows_passed, peak_row);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
